/* sv/vfccf_pkg.sv */
package vfccf_pkg;

    localparam int MAX_BUFFER_DEF = 32;
    localparam int MIN_BUFFER     = 16;
    localparam int FRAME_MARGIN   = 8;
    localparam int QUEUE_DEPTH    = 4;

    localparam logic [5:0]  CAP_RESET = 6'd32;
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'hA001;

    // Wire types placed in the low three bits of a field header.
    localparam logic [2:0] WT_VARINT  = 3'd0;
    localparam logic [2:0] WT_LEN     = 3'd2;
    localparam logic [2:0] WT_FIXED32 = 3'd5;

    localparam logic [2:0] OP_UNSIGNED = 3'd0;
    localparam logic [2:0] OP_SIGNED   = 3'd1;
    localparam logic [2:0] OP_FLOAT    = 3'd2;
    localparam logic [2:0] OP_BLOB_HDR = 3'd3;
    localparam logic [2:0] OP_BLOB_BYTE = 3'd4;

    typedef enum logic [1:0] {
        CMD_PUT,
        CMD_CLOSE,
        CMD_DROP
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind  kind;
        logic [7:0] data;
    } t_cmd;

    typedef enum logic [2:0] {
        F_IDLE,
        F_DROP,
        F_HDR,
        F_VAL,
        F_CLOSE
    } t_front_state;

    typedef enum logic [2:0] {
        B_IDLE,
        B_CRC_LO,
        B_CRC_HI,
        B_FIX,
        B_SEND,
        B_WAIT,
        B_DELIM,
        B_PUT
    } t_back_state;

    // CRC-16/Modbus update by one byte, reflected form.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

/* sv/varint_field_cobs_crc_framer.sv */
// Telemetry framer: tagged fields in, COBS-encoded frames with CRC-16/Modbus out.
// Input channel (i_valid/o_ready) takes one item: opcode, tag and value. Output
// channel (o_valid/i_ready) gives one wire byte per transfer, o_frame_end marking
// the zero delimiter that closes each frame.
// The front end accepts an item when it is idle and spends one cycle per
// generated payload byte (varint, float or blob byte) pushing commands into a
// four-entry queue, holding while the queue is full. An ignored item pushes no
// command; a blob byte pushes its byte and a field its header and value bytes.
// The back end stores each payload byte, already COBS-encoded, in a RAM with a
// registered read. Closing a frame writes the CRC and code fixup (B_CRC_LO,
// B_CRC_HI, B_FIX), then sends each wire byte via B_SEND and B_WAIT, limited by
// the registered RAM read. Blob bytes stream between frame closes, each taken
// once the last is pushed. The first wire byte of a frame is valid after the
// back end, having taken the command that closes it, passes B_CRC_LO to B_WAIT.
// When the receiver stalls, the output register holds the byte, the back end
// waits, the queue fills and the input then stops accepting.
// Reset empties the queue and the frame, clears any pending blob, sets the CRC to
// its initial value and the capacity register to 32. i_cfg_we writes the capacity
// register; the user must write it only while no item is in flight, unenforced.
module varint_field_cobs_crc_framer #(
    parameter int MAX_BUFFER = vfccf_pkg::MAX_BUFFER_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [5:0]  i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_opcode,
    input  logic [7:0]  i_tag,
    input  logic [31:0] i_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_frame_end
);

    logic [5:0]      r_cap;
    logic            q_push, q_full, q_pop, q_empty;
    vfccf_pkg::t_cmd q_din, q_dout;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= vfccf_pkg::CAP_RESET;
        end else if (i_cfg_we) begin
            r_cap <= i_cfg_wdata;
        end
    end

    vfccf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_opcode(i_opcode),
        .i_tag   (i_tag),
        .i_value (i_value),
        .o_push  (q_push),
        .o_cmd   (q_din),
        .i_full  (q_full)
    );

    vfccf_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_din  (q_din),
        .o_full (q_full),
        .i_pop  (q_pop),
        .o_dout (q_dout),
        .o_empty(q_empty)
    );

    vfccf_back #(.MAX_BUFFER(MAX_BUFFER)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cap      (r_cap),
        .i_cmd      (q_dout),
        .i_empty    (q_empty),
        .o_pop      (q_pop),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_out_byte (o_out_byte),
        .o_frame_end(o_frame_end)
    );

endmodule

/* sv/vfccf_ram.sv */
module vfccf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 36
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/vfccf_queue.sv */
module vfccf_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  vfccf_pkg::t_cmd i_din,
    output logic           o_full,
    input  logic           i_pop,
    output vfccf_pkg::t_cmd o_dout,
    output logic           o_empty
);

    localparam int AW = $clog2(vfccf_pkg::QUEUE_DEPTH);

    vfccf_pkg::t_cmd r_slot [vfccf_pkg::QUEUE_DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(vfccf_pkg::QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_dout  = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_din;
        end
    end

endmodule

/* sv/vfccf_front.sv */
module vfccf_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [2:0]      i_opcode,
    input  logic [7:0]      i_tag,
    input  logic [31:0]     i_value,
    output logic            o_push,
    output vfccf_pkg::t_cmd o_cmd,
    input  logic            i_full
);

    vfccf_pkg::t_front_state r_state, n_state;
    logic [10:0] r_hdr, n_hdr;
    logic [31:0] r_val, n_val;
    logic        r_raw, n_raw;
    logic [2:0]  r_cnt, n_cnt;
    logic        r_close, n_close;
    logic [15:0] r_blob, n_blob;

    logic        accept, blob_busy, hdr_last, val_last;
    logic [2:0]  wire_type;

    assign o_ready   = (r_state == vfccf_pkg::F_IDLE);
    assign accept    = i_valid && o_ready;
    assign blob_busy = (r_blob != '0);
    assign hdr_last  = (r_hdr < 11'h080);
    assign val_last  = r_raw ? (r_cnt == 3'd1) : (r_val < 32'h80);

    always_comb begin
        case (i_opcode)
            vfccf_pkg::OP_FLOAT:    wire_type = vfccf_pkg::WT_FIXED32;
            vfccf_pkg::OP_BLOB_HDR: wire_type = vfccf_pkg::WT_LEN;
            default:                wire_type = vfccf_pkg::WT_VARINT;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            vfccf_pkg::F_IDLE: begin
                if (accept) begin
                    if (i_opcode == vfccf_pkg::OP_BLOB_BYTE) begin
                        if (blob_busy) begin
                            n_state = vfccf_pkg::F_VAL;
                        end
                    end else if (i_opcode < vfccf_pkg::OP_BLOB_BYTE) begin
                        n_state = blob_busy ? vfccf_pkg::F_DROP : vfccf_pkg::F_HDR;
                    end
                end
            end
            vfccf_pkg::F_DROP: begin
                if (!i_full) begin
                    n_state = vfccf_pkg::F_HDR;
                end
            end
            vfccf_pkg::F_HDR: begin
                if (!i_full && hdr_last) begin
                    n_state = vfccf_pkg::F_VAL;
                end
            end
            vfccf_pkg::F_VAL: begin
                if (!i_full && val_last) begin
                    n_state = r_close ? vfccf_pkg::F_CLOSE : vfccf_pkg::F_IDLE;
                end
            end
            vfccf_pkg::F_CLOSE: begin
                if (!i_full) begin
                    n_state = vfccf_pkg::F_IDLE;
                end
            end
            default: n_state = vfccf_pkg::F_IDLE;
        endcase
    end

    always_comb begin
        n_hdr   = r_hdr;
        n_val   = r_val;
        n_raw   = r_raw;
        n_cnt   = r_cnt;
        n_close = r_close;
        n_blob  = r_blob;
        o_push  = 1'b0;
        o_cmd   = '{kind: vfccf_pkg::CMD_PUT, data: 8'h00};
        case (r_state)
            vfccf_pkg::F_IDLE: begin
                if (accept) begin
                    n_hdr = {i_tag, wire_type};
                    if (i_opcode == vfccf_pkg::OP_BLOB_BYTE) begin
                        n_val   = {24'h0, i_value[7:0]};
                        n_raw   = 1'b1;
                        n_cnt   = 3'd1;
                        n_close = (r_blob == 16'd1);
                        if (blob_busy) begin
                            n_blob = r_blob - 1'b1;
                        end
                    end else if (i_opcode < vfccf_pkg::OP_BLOB_BYTE) begin
                        n_raw   = (i_opcode == vfccf_pkg::OP_FLOAT);
                        n_cnt   = 3'd4;
                        n_close = 1'b1;
                        n_blob  = '0;
                        case (i_opcode)
                            vfccf_pkg::OP_SIGNED:
                                n_val = {i_value[30:0], 1'b0} ^ {32{i_value[31]}};
                            vfccf_pkg::OP_BLOB_HDR: begin
                                n_val   = {16'h0, i_value[15:0]};
                                n_blob  = i_value[15:0];
                                n_close = (i_value[15:0] == 16'h0);
                            end
                            default: n_val = i_value;
                        endcase
                    end
                end
            end
            vfccf_pkg::F_DROP: begin
                o_push = !i_full;
                o_cmd  = '{kind: vfccf_pkg::CMD_DROP, data: 8'h00};
            end
            vfccf_pkg::F_HDR: begin
                o_push = !i_full;
                o_cmd  = '{kind: vfccf_pkg::CMD_PUT,
                           data: hdr_last ? r_hdr[7:0] : {1'b1, r_hdr[6:0]}};
                if (!i_full) begin
                    n_hdr = r_hdr >> 7;
                end
            end
            vfccf_pkg::F_VAL: begin
                o_push = !i_full;
                if (r_raw) begin
                    o_cmd = '{kind: vfccf_pkg::CMD_PUT, data: r_val[7:0]};
                    if (!i_full) begin
                        n_val = r_val >> 8;
                        n_cnt = r_cnt - 1'b1;
                    end
                end else begin
                    o_cmd = '{kind: vfccf_pkg::CMD_PUT,
                              data: val_last ? r_val[7:0] : {1'b1, r_val[6:0]}};
                    if (!i_full) begin
                        n_val = r_val >> 7;
                    end
                end
            end
            vfccf_pkg::F_CLOSE: begin
                o_push = !i_full;
                o_cmd  = '{kind: vfccf_pkg::CMD_CLOSE, data: 8'h00};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vfccf_pkg::F_IDLE;
            r_blob  <= '0;
        end else begin
            r_state <= n_state;
            r_blob  <= n_blob;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hdr   <= n_hdr;
        r_val   <= n_val;
        r_raw   <= n_raw;
        r_cnt   <= n_cnt;
        r_close <= n_close;
    end

endmodule

/* sv/vfccf_back.sv */
module vfccf_back #(
    parameter int MAX_BUFFER = vfccf_pkg::MAX_BUFFER_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [5:0]      i_cap,
    input  vfccf_pkg::t_cmd i_cmd,
    input  logic            i_empty,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [7:0]      o_out_byte,
    output logic            o_frame_end
);

    localparam int DEPTH = MAX_BUFFER + 4;
    localparam int AW    = $clog2(DEPTH);
    localparam int FW    = $clog2(MAX_BUFFER + 1);

    vfccf_pkg::t_back_state r_state, n_state;
    logic [FW-1:0] r_fill, n_fill;
    logic [15:0]   r_crc, n_crc;
    logic [AW-1:0] r_w, n_w, r_ci, n_ci, r_rd, n_rd;
    logic [7:0]    r_code, n_code;
    logic          r_pend, n_pend;
    logic [7:0]    r_pb, n_pb;
    logic          r_ov, n_ov;
    logic [7:0]    r_ob, n_ob;
    logic          r_oe, n_oe;

    logic          we, re;
    logic [AW-1:0] waddr, raddr;
    logic [7:0]    wdata, rdata;
    logic          enc_en, enc_pay;
    logic [7:0]    enc_b;
    logic [7:0]    cap_c, limit;
    logic          full, slot_free, last_rd;

    always_comb begin
        cap_c = {2'b00, i_cap};
        if (cap_c < 8'(vfccf_pkg::MIN_BUFFER)) begin
            cap_c = 8'(vfccf_pkg::MIN_BUFFER);
        end else if (cap_c > 8'(MAX_BUFFER)) begin
            cap_c = 8'(MAX_BUFFER);
        end
        limit = cap_c - 8'(vfccf_pkg::FRAME_MARGIN);
    end

    assign full      = (8'(r_fill) >= limit);
    assign slot_free = !r_ov || i_ready;
    assign last_rd   = ((r_rd + 1'b1) == r_w);

    vfccf_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_re   (re),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            vfccf_pkg::B_IDLE: begin
                if (!i_empty) begin
                    if (i_cmd.kind == vfccf_pkg::CMD_CLOSE && r_fill != '0) begin
                        n_state = vfccf_pkg::B_CRC_LO;
                    end else if (i_cmd.kind == vfccf_pkg::CMD_PUT && full) begin
                        n_state = vfccf_pkg::B_CRC_LO;
                    end
                end
            end
            vfccf_pkg::B_CRC_LO: n_state = vfccf_pkg::B_CRC_HI;
            vfccf_pkg::B_CRC_HI: n_state = vfccf_pkg::B_FIX;
            vfccf_pkg::B_FIX:    n_state = vfccf_pkg::B_SEND;
            vfccf_pkg::B_SEND:   n_state = vfccf_pkg::B_WAIT;
            vfccf_pkg::B_WAIT: begin
                if (slot_free) begin
                    n_state = last_rd ? vfccf_pkg::B_DELIM : vfccf_pkg::B_SEND;
                end
            end
            vfccf_pkg::B_DELIM: begin
                if (slot_free) begin
                    n_state = r_pend ? vfccf_pkg::B_PUT : vfccf_pkg::B_IDLE;
                end
            end
            vfccf_pkg::B_PUT: n_state = vfccf_pkg::B_IDLE;
            default:          n_state = vfccf_pkg::B_IDLE;
        endcase
    end

    always_comb begin
        n_fill  = r_fill;
        n_crc   = r_crc;
        n_w     = r_w;
        n_ci    = r_ci;
        n_code  = r_code;
        n_rd    = r_rd;
        n_pend  = r_pend;
        n_pb    = r_pb;
        n_ov    = r_ov && !i_ready;
        n_ob    = r_ob;
        n_oe    = r_oe;
        o_pop   = 1'b0;
        we      = 1'b0;
        waddr   = r_w;
        wdata   = 8'h00;
        re      = 1'b0;
        raddr   = r_rd;
        enc_en  = 1'b0;
        enc_pay = 1'b0;
        enc_b   = 8'h00;
        case (r_state)
            vfccf_pkg::B_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    case (i_cmd.kind)
                        vfccf_pkg::CMD_DROP: begin
                            n_fill = '0;
                            n_crc  = vfccf_pkg::CRC_INIT;
                            n_w    = AW'(1);
                            n_ci   = '0;
                            n_code = 8'd1;
                        end
                        vfccf_pkg::CMD_PUT: begin
                            if (full) begin
                                n_pend = 1'b1;
                                n_pb   = i_cmd.data;
                            end else begin
                                enc_en  = 1'b1;
                                enc_pay = 1'b1;
                                enc_b   = i_cmd.data;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            vfccf_pkg::B_CRC_LO: begin
                enc_en = 1'b1;
                enc_b  = r_crc[7:0];
            end
            vfccf_pkg::B_CRC_HI: begin
                enc_en = 1'b1;
                enc_b  = r_crc[15:8];
            end
            vfccf_pkg::B_FIX: begin
                // The last block's code byte goes back into its reserved slot.
                we    = 1'b1;
                waddr = r_ci;
                wdata = r_code;
                n_rd  = '0;
            end
            vfccf_pkg::B_SEND: begin
                re = 1'b1;
            end
            vfccf_pkg::B_WAIT: begin
                if (slot_free) begin
                    n_ov = 1'b1;
                    n_ob = rdata;
                    n_oe = 1'b0;
                    n_rd = r_rd + 1'b1;
                end
            end
            vfccf_pkg::B_DELIM: begin
                if (slot_free) begin
                    n_ov   = 1'b1;
                    n_ob   = 8'h00;
                    n_oe   = 1'b1;
                    n_fill = '0;
                    n_crc  = vfccf_pkg::CRC_INIT;
                    n_w    = AW'(1);
                    n_ci   = '0;
                    n_code = 8'd1;
                end
            end
            vfccf_pkg::B_PUT: begin
                n_pend  = 1'b0;
                enc_en  = 1'b1;
                enc_pay = 1'b1;
                enc_b   = r_pb;
            end
            default: begin
            end
        endcase

        // COBS is built in place: data bytes go to the write pointer, and a zero
        // byte finishes the open block by writing its code into the reserved slot.
        if (enc_en) begin
            we = 1'b1;
            if (enc_b == 8'h00) begin
                waddr  = r_ci;
                wdata  = r_code;
                n_ci   = r_w;
                n_w    = r_w + 1'b1;
                n_code = 8'd1;
            end else begin
                waddr  = r_w;
                wdata  = enc_b;
                n_w    = r_w + 1'b1;
                n_code = r_code + 1'b1;
            end
            if (enc_pay) begin
                n_fill = r_fill + 1'b1;
                n_crc  = vfccf_pkg::crc_byte(r_crc, enc_b);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vfccf_pkg::B_IDLE;
            r_fill  <= '0;
            r_crc   <= vfccf_pkg::CRC_INIT;
            r_w     <= AW'(1);
            r_ci    <= '0;
            r_code  <= 8'd1;
            r_pend  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_crc   <= n_crc;
            r_w     <= n_w;
            r_ci    <= n_ci;
            r_code  <= n_code;
            r_pend  <= n_pend;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd <= n_rd;
        r_pb <= n_pb;
        r_ob <= n_ob;
        r_oe <= n_oe;
    end

    assign o_valid     = r_ov;
    assign o_out_byte  = r_ob;
    assign o_frame_end = r_oe;

endmodule
